/* design/rc4_keystream_generator_unit_defines.svh */
// ---------------------------------------------------------------------------
// RC4 keystream generator assertion macros
// Shared property wrappers clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef RC4_KEYSTREAM_GENERATOR_UNIT_DEFINES_SVH
`define RC4_KEYSTREAM_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define RC4KS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RC4KS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/rc4ks_pkg.sv */
// ---------------------------------------------------------------------------
// rc4ks_pkg
// Types and constants of the RC4 keystream generator.
// ---------------------------------------------------------------------------
package rc4ks_pkg;

  localparam int PERM_DEPTH  = 256;
  localparam int KEY_LEN_W   = 6;
  localparam int REQ_W       = 2;
  localparam int KEY_IDX_W   = 5;

  typedef logic [7:0] byte_t;

  localparam logic [REQ_W-1:0] REQ_KEY_WR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_KSA    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PRGA   = 2'd2;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 6'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P_RD_I,
    ST_P_RD_J,
    ST_P_WR_I,
    ST_P_WR_J,
    ST_P_RD_T,
    ST_P_OUT,
    ST_K_RD_N,
    ST_K_RD_J,
    ST_K_WR_N,
    ST_K_WR_J
  } state_t;

endpackage

/* design/rc4_keystream_generator_unit.sv */
// ---------------------------------------------------------------------------
// rc4_keystream_generator_unit
// RC4 engine: key store, key schedule and keystream generation around one
// single-port 256 x 8 permutation memory.
// ---------------------------------------------------------------------------
//  channel   ports                                       flow control
//  input     start, busy, in_req_type/key_index/key_byte  start & !busy
//  result    out_strobe, out_keystream_byte               one-cycle strobe
//  config    cfg_we, cfg_wdata (key bytes used)           write on cfg_we
//
//  Key write: taken on accept, busy stays low; results are never stalled.
//  Keystream: busy through three reads, two writes of the permutation port
//  and an output state, result strobed in the cycle after the output state.
//  Key schedule: busy over all 256 entries, four permutation accesses per entry.
//  Reset (and each key schedule) clears 256 per-entry valid flops at once;
//  an entry not valid reads as its own address, so no clearing sweep.
// ---------------------------------------------------------------------------
`include "rc4_keystream_generator_unit_defines.svh"

module rc4_keystream_generator_unit #(
  parameter int MAX_KEY_BYTES = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [rc4ks_pkg::REQ_W-1:0]      in_req_type,
  input  logic [rc4ks_pkg::KEY_IDX_W-1:0]  in_key_index,
  input  rc4ks_pkg::byte_t                 in_key_byte,
  output logic                             out_strobe,
  output rc4ks_pkg::byte_t                 out_keystream_byte,
  input  logic                             cfg_we,
  input  logic [rc4ks_pkg::KEY_LEN_W-1:0]  cfg_wdata
);

  import rc4ks_pkg::*;

  localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int LEN_W  = $clog2(MAX_KEY_BYTES + 1);
  localparam logic [9:0] MAX_LEN = 10'(MAX_KEY_BYTES);

  // registers
  state_t                 state_r, state_nxt;
  logic [KEY_LEN_W-1:0]   key_len_cfg_r;
  byte_t                  i_r, j_r;
  byte_t                  s_hold_r;
  byte_t                  t_r;
  logic [KIDX_W-1:0]      kpos_r;
  logic [LEN_W-1:0]       klen_r;
  logic                   out_strobe_r;
  byte_t                  out_byte_r;
  logic [PERM_DEPTH-1:0]  valid_r;

  // memories
  byte_t                  perm_mem [PERM_DEPTH];
  byte_t                  perm_q;
  byte_t                  rd_addr_r;
  byte_t                  key_mem  [MAX_KEY_BYTES];
  byte_t                  key_q;

  // memory port
  logic                   pm_we;
  byte_t                  pm_addr;
  byte_t                  pm_wdata;
  byte_t                  rd_data;

  logic                   accept;
  logic                   key_we;
  logic [9:0]             len_sel;
  logic [LEN_W-1:0]       kpos_inc;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign key_we = accept && (in_req_type == REQ_KEY_WR) && (10'(in_key_index) < MAX_LEN);

  // an entry never written since the last clear holds its own index
  assign rd_data = valid_r[rd_addr_r] ? perm_q : rd_addr_r;

  // key length as used by the schedule: zero means one, clamp at store size
  always_comb begin
    if (key_len_cfg_r == '0) begin
      len_sel = 10'd1;
    end else if (10'(key_len_cfg_r) > MAX_LEN) begin
      len_sel = MAX_LEN;
    end else begin
      len_sel = 10'(key_len_cfg_r);
    end
  end

  assign kpos_inc = LEN_W'(kpos_r) + LEN_W'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_req_type)
            REQ_KSA:  state_nxt = ST_K_RD_N;
            REQ_PRGA: state_nxt = ST_P_RD_I;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_P_RD_I: state_nxt = ST_P_RD_J;
      ST_P_RD_J: state_nxt = ST_P_WR_I;
      ST_P_WR_I: state_nxt = ST_P_WR_J;
      ST_P_WR_J: state_nxt = ST_P_RD_T;
      ST_P_RD_T: state_nxt = ST_P_OUT;
      ST_P_OUT:  state_nxt = ST_IDLE;
      ST_K_RD_N: state_nxt = ST_K_RD_J;
      ST_K_RD_J: state_nxt = ST_K_WR_N;
      ST_K_WR_N: state_nxt = ST_K_WR_J;
      ST_K_WR_J: state_nxt = (i_r == 8'hFF) ? ST_IDLE : ST_K_RD_N;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // permutation port control
  always_comb begin
    pm_we    = 1'b0;
    pm_addr  = i_r;
    pm_wdata = rd_data;
    case (state_r)
      ST_P_RD_I: pm_addr = i_r + 8'd1;
      ST_P_RD_J: pm_addr = j_r + rd_data;
      ST_P_WR_I: begin
        pm_we   = 1'b1;
        pm_addr = i_r;
      end
      ST_P_WR_J: begin
        pm_we    = 1'b1;
        pm_addr  = j_r;
        pm_wdata = s_hold_r;
      end
      ST_P_RD_T: pm_addr = t_r;
      ST_K_RD_N: pm_addr = i_r;
      ST_K_RD_J: pm_addr = j_r + key_q + rd_data;
      ST_K_WR_N: begin
        pm_we   = 1'b1;
        pm_addr = i_r;
      end
      ST_K_WR_J: begin
        pm_we    = 1'b1;
        pm_addr  = j_r;
        pm_wdata = s_hold_r;
      end
      default: pm_addr = i_r;
    endcase
  end

  // permutation memory, one access per cycle
  always_ff @(posedge clk) begin
    if (pm_we) begin
      perm_mem[pm_addr] <= pm_wdata;
    end else begin
      perm_q <= perm_mem[pm_addr];
    end
    rd_addr_r <= pm_addr;
  end

  // key store
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[KIDX_W'(in_key_index)] <= in_key_byte;
    end
    key_q <= key_mem[kpos_r];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      key_len_cfg_r <= KEY_LEN_RESET;
      i_r           <= '0;
      j_r           <= '0;
      kpos_r        <= '0;
      out_strobe_r  <= 1'b0;
      valid_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= (state_r == ST_P_OUT);
      if (cfg_we) begin
        key_len_cfg_r <= cfg_wdata;
      end
      if (accept && (in_req_type == REQ_KSA)) begin
        valid_r <= '0;
        i_r     <= '0;
        j_r     <= '0;
        kpos_r  <= '0;
      end else if (pm_we) begin
        valid_r[pm_addr] <= 1'b1;
      end
      case (state_r)
        ST_P_RD_I: i_r <= pm_addr;
        ST_P_RD_J: j_r <= pm_addr;
        ST_K_RD_J: j_r <= pm_addr;
        ST_K_WR_J: begin
          i_r    <= i_r + 8'd1;
          kpos_r <= (kpos_inc == klen_r) ? '0 : KIDX_W'(kpos_inc);
          if (i_r == 8'hFF) begin
            j_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept && (in_req_type == REQ_KSA)) begin
      klen_r <= LEN_W'(len_sel);
    end
    case (state_r)
      ST_P_RD_J: s_hold_r   <= rd_data;
      ST_K_RD_J: s_hold_r   <= rd_data;
      ST_P_WR_I: t_r        <= s_hold_r + rd_data;
      ST_P_OUT:  out_byte_r <= rd_data;
      default: ;
    endcase
  end

  assign out_strobe         = out_strobe_r;
  assign out_keystream_byte = out_byte_r;

  `RC4KS_ASSERT_NOW(a_strobe_after_out, out_strobe_r, $past(state_r == ST_P_OUT) && !busy, "result strobe without a finished keystream step")
  `RC4KS_ASSERT_NOW(a_no_write_idle, state_r == ST_IDLE, !pm_we, "permutation written while idle")
  `RC4KS_ASSERT_NEXT(a_ksa_clears, accept && (in_req_type == REQ_KSA), (valid_r == '0) && (i_r == '0) && (j_r == '0), "key schedule did not restart from identity")

endmodule
